/* rtl/sfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the sensor frame receiver
// Frame layout, CRC-16 parameters and the status record that the frame
// collector hands to the result register.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int FrameLen = 21;
  localparam int CrcLen   = 19;
  localparam int PosW     = 5;

  localparam logic [7:0]  SYNC_BYTE = 8'hFF;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [PosW-1:0] LAST_POS = PosW'(FrameLen - 1);
  localparam logic [PosW-1:0] CRC_END  = PosW'(CrcLen);

  typedef logic [7:0]      byte_t;
  typedef logic [PosW-1:0] pos_t;
  typedef byte_t [CrcLen-1:0] payload_t;

  // Status of the beat just taken by the collector.
  typedef struct packed {
    logic done;  // the beat closed a frame
    logic ok;    // received CRC matched the computed one
  } frame_stat_t;

endpackage

/* rtl/sfr_crc16_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_crc16_step: one byte of the reflected CRC-16/MODBUS
// Folds one data byte into the running CRC, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module sfr_crc16_step (
  input  logic [15:0]   crc_in,
  input  sfr_pkg::byte_t data_in,
  output logic [15:0]   crc_out
);
  import sfr_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

/* rtl/sfr_collector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_collector: sync hunt, frame capture and running CRC
// Keeps the byte position, the running CRC and the frame bytes, and reports
// the CRC verdict on the beat that closes a frame.
// ----------------------------------------------------------------------------
module sfr_collector (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  sfr_pkg::byte_t        rx_byte,
  output sfr_pkg::payload_t     payload,
  output sfr_pkg::frame_stat_t  stat,
  output logic                  last_pos
);
  import sfr_pkg::*;

  logic        collecting_r, collecting_nxt;
  pos_t        pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_step;
  byte_t       store_r [CrcLen+1];   // bytes 0..19; byte 20 is used on arrival

  sfr_crc16_step u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_step)
  );

  // A position past the end is treated as the last byte.
  assign last_pos = collecting_r && (pos_r >= LAST_POS);

  always_comb begin
    collecting_nxt = collecting_r;
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    stat.done      = 1'b0;
    stat.ok        = ({rx_byte, store_r[CrcLen]} == crc_r);
    if (accept) begin
      if (!collecting_r) begin
        if (rx_byte == SYNC_BYTE) begin
          collecting_nxt = 1'b1;
          pos_nxt        = '0;
          crc_nxt        = CRC_INIT;
        end
      end else if (last_pos) begin
        stat.done      = 1'b1;
        collecting_nxt = 1'b0;
        pos_nxt        = '0;
        crc_nxt        = CRC_INIT;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < CRC_END) begin
          crc_nxt = crc_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      pos_r        <= '0;
      crc_r        <= CRC_INIT;
    end else begin
      collecting_r <= collecting_nxt;
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= CrcLen; i++) begin
      if (accept && collecting_r && !last_pos && (pos_r == PosW'(i))) begin
        store_r[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CrcLen; i++) begin
      payload[i] = store_r[i];
    end
  end

endmodule

/* rtl/sfr_result_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_result_reg: telemetry decode and output register
// Splits the frame into telemetry fields, zeroes them on a CRC failure and
// holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module sfr_result_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 ok,
  input  sfr_pkg::payload_t    payload,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [15:0]   left_speed,
  output logic [7:0]           battery_level,
  output logic [7:0]           left_ir_a,
  output logic [7:0]           left_ir_b,
  output logic [31:0]          left_odometry,
  output logic signed [15:0]   right_speed,
  output logic [7:0]           right_ir_a,
  output logic [7:0]           right_ir_b,
  output logic [31:0]          right_odometry,
  output logic [7:0]           motor_current,
  output logic [7:0]           firmware_version,
  output logic                 frame_ok
);
  import sfr_pkg::*;

  logic     valid_r, valid_nxt;
  payload_t data_r;
  logic     ok_r;

  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= ok ? payload : '0;
      ok_r   <= ok;
    end
  end

  assign out_valid        = valid_r;
  assign left_speed       = {data_r[1], data_r[0]};
  assign battery_level    = data_r[2];
  assign left_ir_a        = data_r[3];
  assign left_ir_b        = data_r[4];
  assign left_odometry    = {data_r[8], data_r[7], data_r[6], data_r[5]};
  assign right_speed      = {data_r[10], data_r[9]};
  assign right_ir_a       = data_r[11];
  assign right_ir_b       = data_r[12];
  assign right_odometry   = {data_r[16], data_r[15], data_r[14], data_r[13]};
  assign motor_current    = data_r[17];
  assign firmware_version = data_r[18];
  assign frame_ok         = ok_r;

endmodule

/* rtl/sensor_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_receiver: serial telemetry deframer with CRC-16/MODBUS check
// Hunts for the 0xFF sync byte, collects a 21-byte frame, checks the CRC of
// bytes 0..18 against the little-endian value in bytes 19..20 and emits one
// decoded telemetry result per frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   in_rx_byte (one serial byte)
//   out_      output     out_valid / out_ready telemetry fields + out_frame_ok
//
// One byte beat is taken every cycle while in_ready is high; the CRC of a byte
// is folded in within that same cycle, so the running CRC register sets the
// rate. A result appears in the cycle after the beat that closes a frame.
// Reset (synchronous, active low) returns the block to sync hunting with no
// result pending. The frame bytes themselves are not reset.
// The input stalls only when the closing byte of a frame arrives while an
// earlier result still waits on a low out_ready; all other beats keep flowing.
// ----------------------------------------------------------------------------
module sensor_frame_receiver (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_left_speed,
  output logic [7:0]           out_battery_level,
  output logic [7:0]           out_left_ir_a,
  output logic [7:0]           out_left_ir_b,
  output logic [31:0]          out_left_odometry,
  output logic signed [15:0]   out_right_speed,
  output logic [7:0]           out_right_ir_a,
  output logic [7:0]           out_right_ir_b,
  output logic [31:0]          out_right_odometry,
  output logic [7:0]           out_motor_current,
  output logic [7:0]           out_firmware_version,
  output logic                 out_frame_ok
);
  import sfr_pkg::*;

  logic        accept;
  logic        last_pos;
  payload_t    payload;
  frame_stat_t stat;

  // Only the frame-closing beat needs a free output slot; the slot is free
  // when it is empty or being drained in this cycle.
  assign in_ready = !last_pos || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  sfr_collector u_collector (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .payload  (payload),
    .stat     (stat),
    .last_pos (last_pos)
  );

  sfr_result_reg u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (stat.done),
    .ok               (stat.ok),
    .payload          (payload),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .left_speed       (out_left_speed),
    .battery_level    (out_battery_level),
    .left_ir_a        (out_left_ir_a),
    .left_ir_b        (out_left_ir_b),
    .left_odometry    (out_left_odometry),
    .right_speed      (out_right_speed),
    .right_ir_a       (out_right_ir_a),
    .right_ir_b       (out_right_ir_b),
    .right_odometry   (out_right_odometry),
    .motor_current    (out_motor_current),
    .firmware_version (out_firmware_version),
    .frame_ok         (out_frame_ok)
  );

  // A frame never closes while a stalled result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.done && out_valid && !out_ready))
    else $error("frame closed while output register was full");

  // A closed frame always shows up as a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> out_valid)
    else $error("closed frame produced no result");

  // A failed CRC check carries no telemetry.
  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_ok) |->
      (out_left_odometry == '0 && out_right_odometry == '0 &&
       out_left_speed == '0 && out_firmware_version == '0))
    else $error("bad frame result carries nonzero telemetry");

endmodule

/* bench/telemetry_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_check_pkg: expected-telemetry scoreboard for the frame receiver
// Tracks sync hunting, frame collection and the CRC-16/MODBUS check on its own
// state, queues the telemetry each closed frame must produce and compares it
// with what the block emits.
// ----------------------------------------------------------------------------
package telemetry_check_pkg;
  import sfr_pkg::*;

  // Field order matches the concatenation of the output ports in the bench.
  typedef struct packed {
    logic signed [15:0] left_speed;
    logic [7:0]         battery_level;
    logic [7:0]         left_ir_a;
    logic [7:0]         left_ir_b;
    logic [31:0]        left_odometry;
    logic signed [15:0] right_speed;
    logic [7:0]         right_ir_a;
    logic [7:0]         right_ir_b;
    logic [31:0]        right_odometry;
    logic [7:0]         motor_current;
    logic [7:0]         firmware_version;
    logic               frame_ok;
  } telemetry_t;

  typedef enum int {
    DMG_NONE,
    DMG_CRC,
    DMG_BODY
  } frame_damage_t;

  // One reflected CRC-16 byte step, LSB first.
  function automatic logic [15:0] crc16_fold(logic [15:0] crc, byte_t b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  class telemetry_scoreboard;
    bit          collecting;
    pos_t        position;
    logic [15:0] running_crc;
    byte_t       frame [FrameLen];
    telemetry_t  expected_frames [$];
    int          errors;
    int          good_frames;
    int          bad_frames;
    int          beats_taken;

    function new();
      collecting  = 1'b0;
      position    = '0;
      running_crc = CRC_INIT;
    endfunction

    // Called for every accepted input beat.
    function void note_byte(byte_t b);
      pos_t       idx;
      telemetry_t exp;
      beats_taken++;
      if (!collecting) begin
        if (b == SYNC_BYTE) begin
          collecting  = 1'b1;
          position    = '0;
          running_crc = CRC_INIT;
        end
        return;
      end
      idx = (position > LAST_POS) ? LAST_POS : position;
      frame[idx] = b;
      if (idx < CRC_END) running_crc = crc16_fold(running_crc, b);
      if (idx < LAST_POS) begin
        position = idx + 1'b1;
        return;
      end
      exp = '0;
      if ({frame[CrcLen+1], frame[CrcLen]} == running_crc) begin
        exp.left_speed       = {frame[1], frame[0]};
        exp.battery_level    = frame[2];
        exp.left_ir_a        = frame[3];
        exp.left_ir_b        = frame[4];
        exp.left_odometry    = {frame[8], frame[7], frame[6], frame[5]};
        exp.right_speed      = {frame[10], frame[9]};
        exp.right_ir_a       = frame[11];
        exp.right_ir_b       = frame[12];
        exp.right_odometry   = {frame[16], frame[15], frame[14], frame[13]};
        exp.motor_current    = frame[17];
        exp.firmware_version = frame[18];
        exp.frame_ok         = 1'b1;
        good_frames++;
      end else begin
        bad_frames++;
      end
      expected_frames.push_back(exp);
      collecting  = 1'b0;
      position    = '0;
      running_crc = CRC_INIT;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    // Called for every accepted result beat.
    function void check_result(telemetry_t got);
      telemetry_t exp;
      if (expected_frames.size() == 0) begin
        $error("result beat arrived with no closed frame pending");
        errors++;
        return;
      end
      exp = expected_frames.pop_front();
      compare_field("left_speed", 32'(unsigned'(exp.left_speed)),
                    32'(unsigned'(got.left_speed)));
      compare_field("battery_level", 32'(exp.battery_level), 32'(got.battery_level));
      compare_field("left_ir_a", 32'(exp.left_ir_a), 32'(got.left_ir_a));
      compare_field("left_ir_b", 32'(exp.left_ir_b), 32'(got.left_ir_b));
      compare_field("left_odometry", exp.left_odometry, got.left_odometry);
      compare_field("right_speed", 32'(unsigned'(exp.right_speed)),
                    32'(unsigned'(got.right_speed)));
      compare_field("right_ir_a", 32'(exp.right_ir_a), 32'(got.right_ir_a));
      compare_field("right_ir_b", 32'(exp.right_ir_b), 32'(got.right_ir_b));
      compare_field("right_odometry", exp.right_odometry, got.right_odometry);
      compare_field("motor_current", 32'(exp.motor_current), 32'(got.motor_current));
      compare_field("firmware_version", 32'(exp.firmware_version),
                    32'(got.firmware_version));
      compare_field("frame_ok", 32'(exp.frame_ok), 32'(got.frame_ok));
    endfunction
  endclass

endpackage

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sensor frame receiver
// Streams serial byte beats (well-formed frames with random telemetry, frames
// with a damaged CRC or body, truncated frames and line noise) into the block
// with random gaps on both sides and checks every telemetry result against
// an independent deframer and CRC-16/MODBUS predictor.
// ----------------------------------------------------------------------------
module testbench;
  import sfr_pkg::*;
  import telemetry_check_pkg::*;

  // About 1250 byte beats overall; the random part stops after this many
  // frame-related beats (line noise is not counted).
  localparam int RandomBeats = 1150;
  // The block answers in the cycle after the closing beat; the spare cycles
  // at the end catch any result that should not be there.
  localparam int DrainCycles = 16;
  // The slowest legal run stays well under this limit, even with every gap at
  // its maximum and the long receiver hold-off.
  localparam int CycleLimit  = 200000;
  // After this many results the receiver holds off long enough for several
  // frames to close, so the block must back-pressure its input.
  localparam int HoldAfter   = 3;
  localparam int HoldCycles  = 300;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte  = 8'h00;
  logic       out_valid;
  logic       out_ready   = 1'b0;

  logic signed [15:0] out_left_speed;
  logic [7:0]         out_battery_level;
  logic [7:0]         out_left_ir_a;
  logic [7:0]         out_left_ir_b;
  logic [31:0]        out_left_odometry;
  logic signed [15:0] out_right_speed;
  logic [7:0]         out_right_ir_a;
  logic [7:0]         out_right_ir_b;
  logic [31:0]        out_right_odometry;
  logic [7:0]         out_motor_current;
  logic [7:0]         out_firmware_version;
  logic               out_frame_ok;

  telemetry_t          dut_result;
  telemetry_scoreboard sb;
  int                  cycles;
  int                  stall_cycles;
  int                  frame_beats;
  bit                  send_burst;

  sensor_frame_receiver u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_left_speed       (out_left_speed),
    .out_battery_level    (out_battery_level),
    .out_left_ir_a        (out_left_ir_a),
    .out_left_ir_b        (out_left_ir_b),
    .out_left_odometry    (out_left_odometry),
    .out_right_speed      (out_right_speed),
    .out_right_ir_a       (out_right_ir_a),
    .out_right_ir_b       (out_right_ir_b),
    .out_right_odometry   (out_right_odometry),
    .out_motor_current    (out_motor_current),
    .out_firmware_version (out_firmware_version),
    .out_frame_ok         (out_frame_ok)
  );

  // The concatenation follows the field order of telemetry_t.
  assign dut_result = {out_left_speed, out_battery_level, out_left_ir_a, out_left_ir_b,
                       out_left_odometry, out_right_speed, out_right_ir_a, out_right_ir_b,
                       out_right_odometry, out_motor_current, out_firmware_version,
                       out_frame_ok};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog. A hung handshake or a result that never shows up ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge, where every input still
  // holds the value driven on the previous edge. Input beats go to the
  // predictor, result beats are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready) sb.check_result(dut_result);
      if (in_valid && !in_ready) stall_cycles++;
    end
  end

  // Offers one byte beat after a random gap. With a zero gap valid simply
  // stays high and only the payload moves on, so valid never drops and
  // rises within one time step. Now and then the sender switches into a
  // stretch of back-to-back beats.
  task automatic send_byte(input byte_t b);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Sends sync, 19 body bytes and the little-endian CRC. A damaged frame
  // either gets one CRC bit flipped or one body bit flipped after the CRC
  // was computed; both must come back with frame_ok low and zero telemetry.
  task automatic send_frame(input payload_t body, input frame_damage_t damage);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < CrcLen; i++) crc = crc16_fold(crc, body[i]);
    if (damage == DMG_CRC) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end else if (damage == DMG_BODY) begin
      body[$urandom_range(0, CrcLen - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end
    send_byte(SYNC_BYTE);
    for (int i = 0; i < CrcLen; i++) send_byte(body[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    frame_beats += FrameLen + 1;
  endtask

  // Random telemetry with a strong pull toward the byte extremes, so speeds
  // and odometry often land on their minimum, maximum and sign boundaries,
  // and sync values turn up inside frames.
  function automatic payload_t random_body();
    payload_t body;
    for (int i = 0; i < CrcLen; i++) begin
      case ($urandom_range(0, 9))
        0:       body[i] = 8'h00;
        1:       body[i] = 8'hFF;
        2:       body[i] = 8'h80;
        3:       body[i] = 8'h7F;
        default: body[i] = 8'($urandom);
      endcase
    end
    return body;
  endfunction

  // Result side: a random wait before each beat, occasional bursts with
  // out_ready held high, and one long hold-off to fill the block up.
  initial begin
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) burst = !burst;
      if (taken == HoldAfter) begin
        gap = HoldCycles;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    payload_t body;
    int       r;
    int       n;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Line noise while hunting: every non-sync byte is dropped silently.
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hFE);

    // Good frame with most negative left speed, most positive right speed,
    // full-scale left odometry and sync values inside the frame body.
    body     = '0;
    body[1]  = 8'h80;
    body[2]  = 8'hFF;
    body[4]  = 8'hFF;
    for (int i = 5; i <= 8; i++) body[i] = 8'hFF;
    body[9]  = 8'hFF;
    body[10] = 8'h7F;
    body[11] = 8'hFF;
    body[17] = 8'h80;
    body[18] = 8'h01;
    send_frame(body, DMG_NONE);

    // Every field at all ones: speeds read as -1, odometry at its maximum.
    send_frame('1, DMG_NONE);

    // A CRC mismatch gives a zeroed result; the frame right after it must
    // be found with no extra sync swallowed.
    send_frame('0, DMG_CRC);
    send_frame('0, DMG_NONE);
    send_frame(random_body(), DMG_BODY);
    send_frame(random_body(), DMG_NONE);

    // Random part: mostly well-formed frames, some damaged, some truncated
    // (the next sync is then taken as frame data) and some line noise that
    // may itself contain a sync value and open a spurious frame.
    frame_beats = 0;
    while (frame_beats < RandomBeats) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        send_frame(random_body(), DMG_NONE);
      end else if (r < 16) begin
        send_frame(random_body(), ($urandom_range(0, 1) == 0) ? DMG_CRC : DMG_BODY);
      end else if (r < 18) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom));
      end else begin
        n = $urandom_range(0, FrameLen - 1);
        send_byte(SYNC_BYTE);
        repeat (n) send_byte(8'($urandom));
        frame_beats += n + 1;
      end
    end
    in_valid <= 1'b0;

    // Let the last result drain, then wait out the drain cycles so a stray
    // result beat would still be caught by the checker.
    @(posedge clk);
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d byte beats: %0d frames with a good CRC, %0d rejected frames.",
             sb.beats_taken, sb.good_frames, sb.bad_frames);
    $display("Input was back-pressured for %0d cycles during the receiver hold-off.",
             stall_cycles);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sfr_pkg.sv
rtl/sfr_crc16_step.sv
rtl/sfr_collector.sv
rtl/sfr_result_reg.sv
rtl/sensor_frame_receiver.sv
bench/telemetry_check_pkg.sv
bench/testbench.sv
